@@ src/blr_pkg.sv @@
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants of the line rasterizer
// Command record passed from the classifier to the stepper, pixel beat
// passed from the stepper to the pair packer, and fixed output limits.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_W     = 8;
  localparam int OUT_X_W     = 7;
  localparam int OUT_Y_W     = 6;
  localparam int MAX_RESULTS = 64;
  localparam int MAX_PIXELS  = 2 * MAX_RESULTS;
  localparam int KEEP_W      = $clog2(MAX_PIXELS + 1);

  // Line in its canonical octant: step u from u0 to u1, v rises on diagonal steps.
  typedef struct packed {
    logic signed [8:0]  u0;
    logic signed [8:0]  v0;
    logic signed [8:0]  u1;
    logic signed [10:0] d0;
    logic signed [10:0] inc_s;
    logic signed [10:0] inc_d;
    logic               mirror;
    logic               swap;
  } cmd_t;

  typedef struct packed {
    logic                 is_end;
    logic                 visible;
    logic [OUT_X_W-1:0]   x;
    logic [OUT_Y_W-1:0]   y;
  } pix_beat_t;

endpackage

@@ src/bresenham_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: line command to visible pixel pairs
// Top level: command intake, queue, stepper and pair packer.
// ----------------------------------------------------------------------------
// A line whose longer axis spans N pixels occupies the stepper for a load
// step, N pixel beats and an end beat that closes the line. The single
// Bresenham stepper makes one pixel per cycle while the output does not
// stall; output stalls hold it. Commands are taken into a two-entry queue
// while the stepper works, and results wait in an output register. Visible
// pixels come out up to two per beat; the final beat of a line carries
// last_of_line, and a line with no visible pixel gives no beat.
module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blr_pkg::COORD_W-1:0]   start_x,
  input  logic [blr_pkg::COORD_W-1:0]   start_y,
  input  logic [blr_pkg::COORD_W-1:0]   end_x,
  input  logic [blr_pkg::COORD_W-1:0]   end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blr_pkg::OUT_X_W-1:0]   first_px_x,
  output logic [blr_pkg::OUT_Y_W-1:0]   first_px_y,
  output logic [blr_pkg::OUT_X_W-1:0]   second_px_x,
  output logic [blr_pkg::OUT_Y_W-1:0]   second_px_y,
  output logic                          second_valid,
  output logic                          last_of_line
);

  blr_pkg::cmd_t      push_cmd;
  blr_pkg::cmd_t      q_head;
  logic               push, pop, q_empty, q_full;
  logic               beat_valid, beat_ready;
  blr_pkg::pix_beat_t beat;

  blr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  blr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  blr_stepper #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  blr_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .beat_valid   (beat_valid),
    .beat_ready   (beat_ready),
    .beat         (beat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_px_x   (first_px_x),
    .first_px_y   (first_px_y),
    .second_px_x  (second_px_x),
    .second_px_y  (second_px_y),
    .second_valid (second_valid),
    .last_of_line (last_of_line)
  );

endmodule

@@ src/blr_front.sv @@
// ----------------------------------------------------------------------------
// blr_front: command intake and octant classification
// Accepts a line command while the queue has room and maps it to the
// canonical octant: ordering, mirroring and axis swap.
// ----------------------------------------------------------------------------
module blr_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blr_pkg::COORD_W-1:0]   start_x,
  input  logic [blr_pkg::COORD_W-1:0]   start_y,
  input  logic [blr_pkg::COORD_W-1:0]   end_x,
  input  logic [blr_pkg::COORD_W-1:0]   end_y,
  input  logic                          q_full,
  output logic                          push,
  output blr_pkg::cmd_t                 cmd
);

  logic              vertical;
  logic              order_swap;
  logic [7:0]        ax, ay, bx, by;
  logic              mirror;
  logic signed [8:0] ya, yb;
  logic [7:0]        dx, dyv;
  logic              steep;
  logic [7:0]        major, minor;
  logic signed [8:0] u0, v0, u1;
  logic              swap;
  logic [7:0]        ylo, yhi;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    vertical   = (start_x == end_x) && (start_y != end_y);
    order_swap = start_x > end_x;
    ax = order_swap ? end_x   : start_x;
    ay = order_swap ? end_y   : start_y;
    bx = order_swap ? start_x : end_x;
    by = order_swap ? start_y : end_y;
    mirror = ay > by;
    ya  = mirror ? -$signed({1'b0, ay}) : $signed({1'b0, ay});
    yb  = mirror ? -$signed({1'b0, by}) : $signed({1'b0, by});
    dx  = bx - ax;
    dyv = 8'(yb - ya);
    steep = dyv > dx;
    ylo = (start_y < end_y) ? start_y : end_y;
    yhi = (start_y < end_y) ? end_y   : start_y;
    if (vertical) begin
      u0    = $signed({1'b0, ylo});
      v0    = $signed({1'b0, start_x});
      u1    = $signed({1'b0, yhi});
      major = yhi - ylo;
      minor = '0;
      swap  = 1'b1;
    end else if (steep) begin
      u0    = ya;
      v0    = $signed({1'b0, ax});
      u1    = yb;
      major = dyv;
      minor = dx;
      swap  = 1'b1;
    end else begin
      u0    = $signed({1'b0, ax});
      v0    = ya;
      u1    = $signed({1'b0, bx});
      major = dx;
      minor = dyv;
      swap  = 1'b0;
    end
    cmd.u0     = u0;
    cmd.v0     = v0;
    cmd.u1     = u1;
    cmd.inc_s  = $signed({2'b00, minor, 1'b0});
    cmd.inc_d  = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
    cmd.d0     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    cmd.mirror = mirror && !vertical;
    cmd.swap   = swap;
  end

endmodule

@@ src/blr_queue.sv @@
// ----------------------------------------------------------------------------
// blr_queue: two-entry command queue
// Decouples command intake from the pixel stepper.
// ----------------------------------------------------------------------------
module blr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  blr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output blr_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  blr_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign empty = count == 2'd0;
  assign full  = count == 2'd2;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

endmodule

@@ src/blr_stepper.sv @@
// ----------------------------------------------------------------------------
// blr_stepper: Bresenham stepper
// Walks the canonical octant one pixel per beat, maps each pixel back to
// the screen, marks visibility and closes the line with an end beat.
// ----------------------------------------------------------------------------
module blr_stepper #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  blr_pkg::cmd_t      q_head,
  output logic               pop,
  output logic               beat_valid,
  input  logic               beat_ready,
  output blr_pkg::pix_beat_t beat
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_END  = 3'b100
  } state_t;

  localparam logic signed [9:0] X_LIM = 10'(SCREEN_WIDTH);
  localparam logic signed [9:0] Y_LIM = 10'(SCREEN_HEIGHT);

  state_t             state, state_next;
  logic signed [8:0]  u, v, u1;
  logic signed [10:0] d, inc_s, inc_d;
  logic               mirror, swap;
  logic signed [9:0]  px, py_raw, py;

  always_comb begin
    px     = swap ? 10'(v) : 10'(u);
    py_raw = swap ? 10'(u) : 10'(v);
    py     = mirror ? -py_raw : py_raw;
  end

  always_comb begin
    beat.is_end  = state == ST_END;
    beat.visible = (px >= 0) && (px < X_LIM) && (py >= 0) && (py < Y_LIM);
    beat.x       = px[blr_pkg::OUT_X_W-1:0];
    beat.y       = py[blr_pkg::OUT_Y_W-1:0];
    beat_valid   = (state == ST_RUN) || (state == ST_END);
    pop          = (state == ST_IDLE) && !q_empty;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (beat_ready && (u == u1)) state_next = ST_END;
      end
      ST_END: begin
        if (beat_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      u      <= q_head.u0;
      v      <= q_head.v0;
      u1     <= q_head.u1;
      d      <= q_head.d0;
      inc_s  <= q_head.inc_s;
      inc_d  <= q_head.inc_d;
      mirror <= q_head.mirror;
      swap   <= q_head.swap;
    end else if ((state == ST_RUN) && beat_ready && (u != u1)) begin
      u <= u + 9'sd1;
      if (d < 0) begin
        d <= d + inc_s;
      end else begin
        v <= v + 9'sd1;
        d <= d + inc_d;
      end
    end
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (u <= u1))
    else $error("stepper ran past line end");

endmodule

@@ src/blr_packer.sv @@
// ----------------------------------------------------------------------------
// blr_packer: pixel pair packer and output register
// Keeps up to MAX_PIXELS visible pixels per line, packs them up to two per result
// and holds the last pair back until the line end tells whether it closes the line.
// ----------------------------------------------------------------------------
module blr_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          beat_valid,
  output logic                          beat_ready,
  input  blr_pkg::pix_beat_t            beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blr_pkg::OUT_X_W-1:0]   first_px_x,
  output logic [blr_pkg::OUT_Y_W-1:0]   first_px_y,
  output logic [blr_pkg::OUT_X_W-1:0]   second_px_x,
  output logic [blr_pkg::OUT_Y_W-1:0]   second_px_y,
  output logic                          second_valid,
  output logic                          last_of_line
);

  logic [1:0]                    cnt;
  logic [blr_pkg::KEEP_W-1:0]    kept;
  logic [blr_pkg::OUT_X_W-1:0]   a_x, b_x;
  logic [blr_pkg::OUT_Y_W-1:0]   a_y, b_y;
  logic                          keep;
  logic                          need;
  logic                          load_ok;
  logic                          fire;
  logic                          load;

  always_comb begin
    keep    = !beat.is_end && beat.visible && (kept < blr_pkg::KEEP_W'(blr_pkg::MAX_PIXELS));
    need    = beat.is_end ? (cnt != 2'd0) : (keep && (cnt == 2'd2));
    load_ok = !out_valid || out_ready;
    beat_ready = !need || load_ok;
    fire    = beat_valid && beat_ready;
    load    = fire && need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      kept      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (beat.is_end) begin
          cnt  <= 2'd0;
          kept <= '0;
        end else if (keep) begin
          kept <= kept + 1'b1;
          cnt  <= (cnt == 2'd1) ? 2'd2 : 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_px_x   <= a_x;
      first_px_y   <= a_y;
      second_px_x  <= (cnt == 2'd2) ? b_x : '0;
      second_px_y  <= (cnt == 2'd2) ? b_y : '0;
      second_valid <= cnt == 2'd2;
      last_of_line <= beat.is_end;
    end
    if (fire && keep) begin
      if (cnt == 2'd1) begin
        b_x <= beat.x;
        b_y <= beat.y;
      end else begin
        a_x <= beat.x;
        a_y <= beat.y;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("pair slot overfilled");
  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    (fire && beat.is_end) |=> (cnt == 2'd0))
    else $error("pair slot not cleared at line end");

endmodule
